[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[sv/rpn_pkg.sv]
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the postfix/prefix stack evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int DATA_W          = 32;
	localparam int CHAR_W          = 8;
	localparam int STATUS_W        = 3;
	localparam int APB_ADDR_W      = 3;
	localparam int APB_DATA_W      = 32;
	localparam int DIV_STEPS       = 32;
	localparam int DIV_STEP_W      = 5;

	// Register word index (paddr bit above the byte offset)
	localparam logic REG_IDX_PREFIX_MODE = 1'b0;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 3'd0,
		STATUS_UNDERFLOW = 3'd1,
		STATUS_OVERFLOW  = 3'd2,
		STATUS_DIVZERO   = 3'd3,
		STATUS_INVALID   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP
	} cell_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

endpackage

[sv/rpn_stack_evaluator.sv]
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Postfix/prefix integer expression evaluator, one character per transfer.
// ----------------------------------------------------------------------------
// Digits, spaces, + - * and errors are handled in the idle state; '/' hands
// off to the bit-serial divider (32 steps plus load and commit).
// The result appears in the output register in the cycle after the last character
// (after the division when the last character is '/').
// Reset clears stack count, error, mode and handshake state; stack words are
// not cleared and are read only below the count.
module rpn_stack_evaluator #(
	parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rpn_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [rpn_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [rpn_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready,
	input  logic                               char_valid,
	output logic                               char_stall,
	input  logic [rpn_pkg::CHAR_W-1:0]         char_code,
	input  logic                               is_last,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic signed [rpn_pkg::DATA_W-1:0]  result_value,
	output logic [rpn_pkg::STATUS_W-1:0]       status
);

	localparam int W     = rpn_pkg::DATA_W;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

	logic                  prefix_mode_q;
	rpn_pkg::state_t       state_q, state_d;
	logic [CNT_W-1:0]      count_q, count_d;
	rpn_pkg::status_t      err_q, err_d;
	logic                  last_q, last_d;
	logic                  result_valid_q;
	logic [W-1:0]          result_value_q;
	rpn_pkg::status_t      status_q;

	logic [W-1:0]          cell_val [STACK_DEPTH];
	rpn_pkg::cell_cmd_t    cell_cmd;
	logic [W-1:0]          push_in;
	logic [W-1:0]          pop_in;

	logic                  div_start;
	logic                  div_done;
	logic [W-1:0]          div_quo;

	logic                  accept;
	logic                  is_digit, is_op;
	logic [W-1:0]          lhs, rhs, alu_r;
	logic                  out_load;
	logic [W-1:0]          out_value;
	rpn_pkg::status_t      out_status;
	rpn_pkg::status_t      step_err, fin_err;
	logic [CNT_W-1:0]      step_cnt;
	logic [W-1:0]          step_top;
	logic                  go_div;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign prdata = (paddr[rpn_pkg::APB_ADDR_W-1] == rpn_pkg::REG_IDX_PREFIX_MODE) ?
		{{(rpn_pkg::APB_DATA_W-1){1'b0}}, prefix_mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
				paddr[rpn_pkg::APB_ADDR_W-1] == rpn_pkg::REG_IDX_PREFIX_MODE) begin
			prefix_mode_q <= pwdata[0];
		end
	end

	// ---------------- stack cells ----------------
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [W-1:0] up_val;
		logic [W-1:0] down_val;
		if (i == 0) begin : g_top
			assign up_val   = push_in;
			assign down_val = pop_in;
		end else if (i == STACK_DEPTH - 1) begin : g_bottom
			assign up_val   = cell_val[i-1];
			assign down_val = cell_val[i];
		end else begin : g_mid
			assign up_val   = cell_val[i-1];
			assign down_val = cell_val[i+1];
		end
		rpn_cell u_cell (
			.clk      (clk),
			.cmd      (cell_cmd),
			.up_val   (up_val),
			.down_val (down_val),
			.value    (cell_val[i])
		);
	end

	// ---------------- arithmetic ----------------
	assign is_digit = (char_code >= rpn_pkg::CHAR_ZERO) && (char_code <= rpn_pkg::CHAR_NINE);
	assign is_op    = (char_code == rpn_pkg::CHAR_PLUS) || (char_code == rpn_pkg::CHAR_MINUS) ||
		(char_code == rpn_pkg::CHAR_STAR) || (char_code == rpn_pkg::CHAR_SLASH);

	// prefix input arrives reversed, so the top of stack is the left operand
	assign lhs = prefix_mode_q ? cell_val[0] : cell_val[1];
	assign rhs = prefix_mode_q ? cell_val[1] : cell_val[0];

	always_comb begin
		case (char_code)
			rpn_pkg::CHAR_PLUS:  alu_r = lhs + rhs;
			rpn_pkg::CHAR_MINUS: alu_r = lhs - rhs;
			rpn_pkg::CHAR_STAR:  alu_r = lhs * rhs;
			default:             alu_r = '0;
		endcase
	end

	assign push_in = {{(W-4){1'b0}}, char_code[3:0]};
	assign pop_in  = (state_q == rpn_pkg::ST_DIV) ? div_quo : alu_r;

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lhs),
		.divisor  (rhs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// ---------------- control ----------------
	assign char_stall = (state_q != rpn_pkg::ST_IDLE) ||
		(is_last && result_valid_q && result_stall);
	assign accept     = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpn_pkg::ST_IDLE;
			count_q <= '0;
			err_q   <= rpn_pkg::STATUS_OK;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			err_q   <= err_d;
			last_q  <= last_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		err_d      = err_q;
		last_d     = last_q;
		cell_cmd   = rpn_pkg::CELL_HOLD;
		div_start  = 1'b0;
		out_load   = 1'b0;
		out_value  = '0;
		out_status = rpn_pkg::STATUS_OK;
		step_err   = err_q;
		step_cnt   = count_q;
		step_top   = cell_val[0];
		fin_err    = rpn_pkg::STATUS_OK;
		go_div     = 1'b0;

		case (state_q)
			rpn_pkg::ST_IDLE: begin
				if (accept) begin
					// drop everything once an error is pending
					if (err_q == rpn_pkg::STATUS_OK && char_code != rpn_pkg::CHAR_SPACE) begin
						if (is_digit) begin
							if (count_q == CNT_FULL) begin
								step_err = rpn_pkg::STATUS_OVERFLOW;
							end else begin
								cell_cmd = rpn_pkg::CELL_PUSH;
								step_cnt = count_q + CNT_W'(1);
								step_top = push_in;
							end
						end else if (is_op) begin
							if (count_q < CNT_W'(2)) begin
								step_err = rpn_pkg::STATUS_UNDERFLOW;
							end else if (char_code == rpn_pkg::CHAR_SLASH) begin
								if (rhs == '0) begin
									step_err = rpn_pkg::STATUS_DIVZERO;
								end else begin
									go_div = 1'b1;
								end
							end else begin
								cell_cmd = rpn_pkg::CELL_POP;
								step_cnt = count_q - CNT_W'(1);
								step_top = alu_r;
							end
						end else begin
							step_err = rpn_pkg::STATUS_INVALID;
						end
					end

					if (go_div) begin
						div_start = 1'b1;
						state_d   = rpn_pkg::ST_DIV;
						last_d    = is_last;
					end else if (is_last) begin
						fin_err    = (step_err == rpn_pkg::STATUS_OK && step_cnt == '0) ?
							rpn_pkg::STATUS_UNDERFLOW : step_err;
						out_load   = 1'b1;
						out_status = fin_err;
						out_value  = (fin_err == rpn_pkg::STATUS_OK) ? step_top : '0;
						count_d    = '0;
						err_d      = rpn_pkg::STATUS_OK;
					end else begin
						count_d = step_cnt;
						err_d   = step_err;
					end
				end
			end
			rpn_pkg::ST_DIV: begin
				if (div_done) begin
					cell_cmd = rpn_pkg::CELL_POP;
					state_d  = rpn_pkg::ST_IDLE;
					if (last_q) begin
						out_load   = 1'b1;
						out_status = rpn_pkg::STATUS_OK;
						out_value  = div_quo;
						count_d    = '0;
						err_d      = rpn_pkg::STATUS_OK;
					end else begin
						count_d = count_q - CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = rpn_pkg::ST_IDLE;
			end
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_value_q <= out_value;
			status_q       <= out_status;
		end
	end

	assign result_valid = result_valid_q;
	assign result_value = result_value_q;
	assign status       = status_q;

endmodule

[sv/rpn_cell.sv]
// ----------------------------------------------------------------------------
// rpn_cell
// One stack entry: holds a word, takes it from the cell above on a push and
// from the cell below on a pop.
// ----------------------------------------------------------------------------
module rpn_cell (
	input  logic                          clk,
	input  rpn_pkg::cell_cmd_t            cmd,
	input  logic [rpn_pkg::DATA_W-1:0]    up_val,
	input  logic [rpn_pkg::DATA_W-1:0]    down_val,
	output logic [rpn_pkg::DATA_W-1:0]    value
);

	logic [rpn_pkg::DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		case (cmd)
			rpn_pkg::CELL_PUSH: value_q <= up_val;
			rpn_pkg::CELL_POP:  value_q <= down_val;
			default:            value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule

[sv/rpn_div.sv]
// ----------------------------------------------------------------------------
// rpn_div
// Signed 32-bit divider, truncating toward zero; restoring, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module rpn_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rpn_pkg::DATA_W-1:0]    dividend,
	input  logic [rpn_pkg::DATA_W-1:0]    divisor,
	output logic                          done,
	output logic [rpn_pkg::DATA_W-1:0]    quotient
);

	localparam int W = rpn_pkg::DATA_W;

	logic                          busy_q;
	logic                          done_q;
	logic [rpn_pkg::DIV_STEP_W-1:0] step_q;
	logic [W-1:0]                  rem_q;
	logic [W-1:0]                  quo_q;
	logic [W-1:0]                  dvs_q;
	logic                          neg_q;

	logic [W:0]   rem_sh;
	logic [W:0]   diff;
	logic [W-1:0] mag_a;
	logic [W-1:0] mag_b;

	assign mag_a  = dividend[W-1] ? (~dividend + W'(1)) : dividend;
	assign mag_b  = divisor[W-1]  ? (~divisor + W'(1))  : divisor;
	assign rem_sh = {rem_q, quo_q[W-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + rpn_pkg::DIV_STEP_W'(1);
				if (step_q == rpn_pkg::DIV_STEP_W'(rpn_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			dvs_q <= mag_b;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			// keep the partial remainder when the trial subtract goes negative
			rem_q <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[W-2:0], ~diff[W]};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + W'(1)) : quo_q;

endmodule

[sv/rpn_checker.sv]
// ----------------------------------------------------------------------------
// rpn_checker
// Port-level checks on the stack evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpn_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               char_valid,
	input logic                               char_stall,
	input logic [rpn_pkg::CHAR_W-1:0]         char_code,
	input logic                               is_last,
	input logic                               result_valid,
	input logic                               result_stall,
	input logic signed [rpn_pkg::DATA_W-1:0]  result_value,
	input logic [rpn_pkg::STATUS_W-1:0]       status
);

	// a waiting result holds until transfer
	`ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall,
		result_valid && $stable(result_value) && $stable(status))

	// an error reports a zero value
	`ASSERT_IMPL(a_err_zero, clk, arst_n, result_valid && status != rpn_pkg::STATUS_OK,
		result_value == '0)

	// a last character other than a division reports on the next cycle
	`ASSERT_NEXT(a_last_result, clk, arst_n,
		char_valid && !char_stall && is_last && char_code != rpn_pkg::CHAR_SLASH, result_valid)

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.char_valid   (char_valid),
	.char_stall   (char_stall),
	.char_code    (char_code),
	.is_last      (is_last),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_value (result_value),
	.status       (status)
);

[tb/sv/rpn_checker.sv]
// ----------------------------------------------------------------------------
// rpn_tb_checker
// Watches the configuration port and both character/result channels of the
// stack evaluator, predicts every result from its own copy of the operand
// stack, and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module rpn_tb_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rpn_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [rpn_pkg::APB_DATA_W-1:0]    pwdata,
	input  logic [rpn_pkg::APB_DATA_W-1:0]    prdata,
	input  logic                              pready,
	input  logic                              char_valid,
	input  logic                              char_stall,
	input  logic [rpn_pkg::CHAR_W-1:0]        char_code,
	input  logic                              is_last,
	input  logic                              result_valid,
	input  logic                              result_stall,
	input  logic signed [rpn_pkg::DATA_W-1:0] result_value,
	input  logic [rpn_pkg::STATUS_W-1:0]      status,
	output int                                fail_count,
	output int                                outstanding,
	output int                                results_seen,
	output int                                error_results
);

	localparam int DEPTH = rpn_pkg::STACK_DEPTH_DEF;
	localparam int DW    = rpn_pkg::DATA_W;
	localparam int CW    = rpn_pkg::CHAR_W;

	typedef struct packed {
		logic [DW-1:0]    value;
		rpn_pkg::status_t code;
	} outcome_t;

	logic [DW-1:0]     vals [DEPTH];
	int                fill;
	rpn_pkg::status_t  fault;
	logic              swap_operands;
	outcome_t          awaited [$];
	int                fails = 0;
	int                seen = 0;
	int                errs = 0;

	function automatic logic [DW-1:0] quot_trunc(input logic [DW-1:0] num,
		input logic [DW-1:0] den);
		logic [DW-1:0] mag_n, mag_d, q;
		mag_n = num[DW-1] ? -num : num;
		mag_d = den[DW-1] ? -den : den;
		q = mag_n / mag_d;
		return (num[DW-1] ^ den[DW-1]) ? -q : q;
	endfunction

	task automatic absorb_char(input logic [CW-1:0] c, input logic last);
		logic [DW-1:0] top, below, lhs, rhs, r;
		outcome_t      o;
		r = '0;
		if (fault == rpn_pkg::STATUS_OK && c != rpn_pkg::CHAR_SPACE) begin
			if (c >= rpn_pkg::CHAR_ZERO && c <= rpn_pkg::CHAR_NINE) begin
				if (fill >= DEPTH) begin
					fault = rpn_pkg::STATUS_OVERFLOW;
				end else begin
					vals[fill] = {{(DW-CW){1'b0}}, c - rpn_pkg::CHAR_ZERO};
					fill++;
				end
			end else if (c == rpn_pkg::CHAR_PLUS || c == rpn_pkg::CHAR_MINUS ||
				c == rpn_pkg::CHAR_STAR || c == rpn_pkg::CHAR_SLASH) begin
				if (fill < 2) begin
					fault = rpn_pkg::STATUS_UNDERFLOW;
				end else begin
					top   = vals[fill-1];
					below = vals[fill-2];
					// prefix streams arrive reversed, so the top is the left operand
					lhs = swap_operands ? top : below;
					rhs = swap_operands ? below : top;
					case (c)
						rpn_pkg::CHAR_PLUS:  r = lhs + rhs;
						rpn_pkg::CHAR_MINUS: r = lhs - rhs;
						rpn_pkg::CHAR_STAR:  r = lhs * rhs;
						default: begin
							if (rhs == '0) fault = rpn_pkg::STATUS_DIVZERO;
							else r = quot_trunc(lhs, rhs);
						end
					endcase
					if (fault == rpn_pkg::STATUS_OK) begin
						fill--;
						vals[fill-1] = r;
					end
				end
			end else begin
				fault = rpn_pkg::STATUS_INVALID;
			end
		end
		if (last) begin
			if (fault == rpn_pkg::STATUS_OK && fill == 0) fault = rpn_pkg::STATUS_UNDERFLOW;
			o.code  = fault;
			o.value = (fault == rpn_pkg::STATUS_OK) ? vals[fill-1] : '0;
			awaited.push_back(o);
			fill  = 0;
			fault = rpn_pkg::STATUS_OK;
		end
	endtask

	task automatic check_result();
		outcome_t want;
		if (awaited.size() == 0) begin
			$display("%0t: result with nothing expected: value %0d status %0d",
				$time, result_value, status);
			fails++;
		end else begin
			want = awaited.pop_front();
			seen++;
			if (want.code != rpn_pkg::STATUS_OK) errs++;
			if (result_value !== want.value) begin
				$display("%0t: result_value expected %0d, actual %0d",
					$time, $signed(want.value), result_value);
				fails++;
			end
			if (status !== want.code) begin
				$display("%0t: status expected %0d, actual %0d", $time, want.code, status);
				fails++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill = 0;
			fault = rpn_pkg::STATUS_OK;
			swap_operands = 1'b0;
			awaited.delete();
			fail_count <= 0;
			outstanding <= 0;
			results_seen <= 0;
			error_results <= 0;
		end else begin
			if (psel && penable && pready &&
				paddr[rpn_pkg::APB_ADDR_W-1:2] == rpn_pkg::REG_IDX_PREFIX_MODE) begin
				if (pwrite) begin
					swap_operands = pwdata[0];
				end else if (prdata !== {{(rpn_pkg::APB_DATA_W-1){1'b0}}, swap_operands}) begin
					$display("%0t: prefix_mode read expected %0d, actual %0d",
						$time, swap_operands, prdata);
					fails++;
				end
			end
			// results leave before the character of this edge can add one
			if (result_valid && !result_stall) check_result();
			if (char_valid && !char_stall) absorb_char(char_code, is_last);
			fail_count <= fails;
			outstanding <= awaited.size();
			results_seen <= seen;
			error_results <= errs;
		end
	end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives expressions into the stack evaluator in postfix and prefix order:
// a short directed set for the corner cases, then random well-formed trees
// mixed with broken and noisy streams, under random gaps and stalls on both
// channels. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CW        = rpn_pkg::CHAR_W;
	localparam int AW        = rpn_pkg::APB_ADDR_W;
	localparam int PW        = rpn_pkg::APB_DATA_W;
	localparam int ITEM_GOAL = 1450;
	localparam int PHASES    = 6;
	localparam int HOLD_OFF  = 400;
	localparam int SETTLE    = 40;
	localparam int MAX_GAP   = 17;
	localparam logic [AW-1:0] ADDR_PREFIX_MODE = {rpn_pkg::REG_IDX_PREFIX_MODE, 2'b00};

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              psel = 1'b0;
	logic                              penable = 1'b0;
	logic                              pwrite = 1'b0;
	logic [AW-1:0]                     paddr = '0;
	logic [PW-1:0]                     pwdata = '0;
	logic [PW-1:0]                     prdata;
	logic                              pready;
	logic                              char_valid = 1'b0;
	logic                              char_stall;
	logic [CW-1:0]                     char_code = '0;
	logic                              is_last = 1'b0;
	logic                              result_valid;
	logic                              result_stall = 1'b0;
	logic signed [rpn_pkg::DATA_W-1:0] result_value;
	logic [rpn_pkg::STATUS_W-1:0]      status;

	int fail_count, outstanding, results_seen, error_results;

	logic [CW-1:0]     expr_chars [$];
	bit                gaps_on = 1'b1;
	bit                long_hold = 1'b0;
	bit                mode_now = 1'b0;
	int                chars_sent = 0;
	int                busy_chars = 0;
	int                exprs_sent = 0;

	always #10 clk = ~clk;

	rpn_stack_evaluator dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.char_valid(char_valid), .char_stall(char_stall),
		.char_code(char_code), .is_last(is_last),
		.result_valid(result_valid), .result_stall(result_stall),
		.result_value(result_value), .status(status)
	);

	rpn_tb_checker chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.char_valid(char_valid), .char_stall(char_stall),
		.char_code(char_code), .is_last(is_last),
		.result_valid(result_valid), .result_stall(result_stall),
		.result_value(result_value), .status(status),
		.fail_count(fail_count), .outstanding(outstanding),
		.results_seen(results_seen), .error_results(error_results)
	);

	function automatic logic [CW-1:0] pick_digit();
		return rpn_pkg::CHAR_ZERO +
			CW'(($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 9));
	endfunction

	function automatic logic [CW-1:0] pick_op();
		case ($urandom_range(0, 3))
			0: return rpn_pkg::CHAR_PLUS;
			1: return rpn_pkg::CHAR_MINUS;
			2: return rpn_pkg::CHAR_STAR;
			default: return rpn_pkg::CHAR_SLASH;
		endcase
	endfunction

	task automatic send_char(input logic [CW-1:0] c, input logic last);
		int gap;
		gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_code <= c;
		is_last <= last;
		do @(posedge clk); while (char_stall);
		chars_sent++;
		if (c != rpn_pkg::CHAR_SPACE) busy_chars++;
	endtask

	// send the buffered characters; close marks the final one as last
	task automatic play(input bit close);
		for (int i = 0; i < expr_chars.size(); i++)
			send_char(expr_chars[i], close && i == expr_chars.size() - 1);
		expr_chars.delete();
		exprs_sent++;
	endtask

	task automatic load(input string s);
		for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
	endtask

	task automatic put(input logic [CW-1:0] c);
		expr_chars.push_back(c);
		if ($urandom_range(0, 9) == 0) expr_chars.push_back(rpn_pkg::CHAR_SPACE);
	endtask

	task automatic grow(input int depth);
		logic [CW-1:0] op;
		if (depth == 0 || $urandom_range(0, 3) == 0) begin
			put(pick_digit());
		end else begin
			op = pick_op();
			grow(depth - 1);
			grow(depth - 1);
			put(op);
		end
	endtask

	// 2 * 8^10 wraps to the most negative word, then divide it by -1
	task automatic build_wrap();
		if (mode_now) load("10-");
		load("2");
		repeat (10) load("8*");
		if (!mode_now) load("01-");
		load("/");
	endtask

	task automatic random_expr();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 68) begin
			grow($urandom_range(0, 5));
		end else if (roll < 76) begin
			grow($urandom_range(0, 4));
			put($urandom_range(0, 1) ? pick_digit() : pick_op());
		end else if (roll < 82) begin
			repeat ($urandom_range(14, 19)) put(pick_digit());
		end else if (roll < 88) begin
			repeat ($urandom_range(1, 5)) expr_chars.push_back(CW'($urandom_range(0, 255)));
		end else if (roll < 93) begin
			grow($urandom_range(1, 4));
			expr_chars.insert($urandom_range(0, expr_chars.size()),
				CW'($urandom_range(0, 255)));
		end else if (roll < 96) begin
			build_wrap();
		end else begin
			expr_chars.push_back($urandom_range(0, 1) ? rpn_pkg::CHAR_SPACE : pick_op());
		end
	endtask

	task automatic apb_access(input bit wr, input logic [PW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_PREFIX_MODE;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// return to idle between accesses
		@(posedge clk);
	endtask

	// drop valid, drain all results, then let a full divide finish
	task automatic settle();
		char_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_mode(input bit m);
		settle();
		apb_access(1'b1, {{(PW-1){1'b0}}, m});
		apb_access(1'b0, '0);
		mode_now = m;
	endtask

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = long_hold ? HOLD_OFF : (gaps_on ? $urandom_range(0, MAX_GAP) : 0);
			long_hold = 1'b0;
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
		end
	end

	initial begin
		int wait_cycles;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load("93-");  play(1'b1);
		load("45*");  play(1'b1);
		load("8 2/"); play(1'b1);
		load("123+"); play(1'b1);
		load("+");    play(1'b1);
		load(" ");    play(1'b1);
		load("50/3"); play(1'b1);
		load("1");
		expr_chars.push_back(8'hFF);
		load("2");    play(1'b1);
		expr_chars.push_back(8'h00);
		play(1'b1);
		// switch notation halfway through an expression
		set_mode(1'b1);
		load("82");   play(1'b0);
		set_mode(1'b0);
		load("-");    play(1'b1);

		for (int p = 0; p < PHASES; p++) begin
			set_mode(1'((p < 4) ? (p % 2 == 0) : $urandom_range(0, 1)));
			gaps_on = (p != 2);
			long_hold = (p == 2 || p == 4);
			if (p < 2) begin
				build_wrap();
				play(1'b1);
				repeat (17) put(pick_digit());
				play(1'b1);
			end
			while (chars_sent < ITEM_GOAL * (p + 1) / PHASES) begin
				random_expr();
				play(1'b1);
			end
		end

		char_valid <= 1'b0;
		@(posedge clk);
		for (wait_cycles = 0; outstanding != 0 && wait_cycles < 5000; wait_cycles++)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d characters (%0d non-space) in %0d expressions, both notations",
			chars_sent, busy_chars, exprs_sent);
		$display("checked %0d results, %0d of them error reports", results_seen,
			error_results);
		if (fail_count == 0 && outstanding == 0) begin
			$display("status: pass");
		end else begin
			if (outstanding != 0) $display("%0t: %0d results never arrived", $time, outstanding);
			$display("status: fail");
		end
		$finish;
	end

endmodule
